/* rtl/ltns_pkg.sv */
package ltns_pkg;

	localparam logic [1:0] ACT_PASS  = 2'd0;
	localparam logic [1:0] ACT_SCAN  = 2'd1;
	localparam logic [1:0] ACT_TRACE = 2'd2;
	localparam logic [1:0] ACT_STOP  = 2'd3;

	localparam logic [1:0] KIND_DRIVE  = 2'd0;
	localparam logic [1:0] KIND_NODE   = 2'd1;
	localparam logic [1:0] KIND_SHOT   = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [2:0] CMD_STOP  = 3'd0;
	localparam logic [2:0] CMD_FWD   = 3'd1;
	localparam logic [2:0] CMD_BACK  = 3'd2;
	localparam logic [2:0] CMD_LEFT  = 3'd3;
	localparam logic [2:0] CMD_RIGHT = 3'd4;

	localparam logic [1:0] ST_GOING    = 2'd0;
	localparam logic [1:0] ST_RETURN   = 2'd1;
	localparam logic [1:0] ST_COMPLETE = 2'd2;
	localparam logic [1:0] ST_STOPPED  = 2'd3;

	localparam logic [2:0] REG_WAYPOINTS = 3'd0;
	localparam logic [2:0] REG_PAN       = 3'd1;
	localparam logic [2:0] REG_TILT      = 3'd2;
	localparam logic [2:0] REG_STEP      = 3'd3;
	localparam logic [2:0] REG_ROUNDS    = 3'd4;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_RET  = 2'd2;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_NODE    = 3'd1;
	localparam logic [2:0] PH_REPORT  = 3'd2;
	localparam logic [2:0] PH_LEAVE   = 3'd3;
	localparam logic [2:0] PH_SETTLE  = 3'd4;
	localparam logic [2:0] PH_CAPTURE = 3'd5;

	localparam logic [5:0] CODE_START = 6'h19;
	localparam logic [5:0] CODE_BASE  = 6'h20;
	localparam logic [11:0] NODE_WAIT_MS = 12'd3000;
	localparam logic [11:0] LEAVE_MS     = 12'd250;
	localparam logic [11:0] CAPTURE_MS   = 12'd500;
	localparam logic [5:0] SPEED_TURN = 6'd35;
	localparam logic [5:0] SPEED_LINE = 6'd25;

	localparam int MAX_RES = 5;
	localparam int QUEUE_DEPTH_DEF = 8;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] drive_cmd;
		logic [5:0] drive_speed;
		logic [5:0] node_tag;
		logic [6:0] shot_tilt;
		logic [7:0] shot_pan;
		logic [1:0] scan_status;
	} res_t;

	typedef struct packed {
		logic [2:0] cnt;
		res_t [MAX_RES-1:0] res;
	} batch_t;

	function automatic res_t mk_drive(input logic [2:0] c, input logic [5:0] s);
		res_t r;
		r = '0;
		r.kind = KIND_DRIVE;
		r.drive_cmd = c;
		r.drive_speed = s;
		return r;
	endfunction

	function automatic res_t mk_status(input logic [1:0] st);
		res_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.scan_status = st;
		return r;
	endfunction

	function automatic res_t mk_node(input logic [5:0] c);
		res_t r;
		r = '0;
		r.kind = KIND_NODE;
		r.node_tag = c;
		return r;
	endfunction

	function automatic res_t mk_shot(input logic [6:0] t, input logic [7:0] p);
		res_t r;
		r = '0;
		r.kind = KIND_SHOT;
		r.shot_tilt = t;
		r.shot_pan = p;
		return r;
	endfunction

endpackage

/* rtl/line_track_node_scan_controller.sv */
// Channel  Handshake              Payload
// in       in_valid / in_ready    action, now_ms, front_left, front_right, rear_sensors
// out      out_valid / out_ready  kind, drive_cmd, ... , scan_status, last
// cfg      cfg_we                 cfg_index, cfg_data
// The front takes one word per cycle and classifies it in that cycle; its results go
// into a batch queue as one entry. The back sends one result word per cycle from the
// queue head while out_ready is high. The front stalls only when the queue is full.
// Reset clears all state except the queue storage at once.
module line_track_node_scan_controller import ltns_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] now_ms,
	input  logic        front_left,
	input  logic        front_right,
	input  logic [3:0]  rear_sensors,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [2:0]  drive_cmd,
	output logic [5:0]  drive_speed,
	output logic [5:0]  node_tag,
	output logic [6:0]  shot_tilt,
	output logic [7:0]  shot_pan,
	output logic [1:0]  scan_status,
	output logic        last
);

	logic   q_push, q_full;
	batch_t q_data;

	ltns_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .action, .now_ms, .front_left,
		.front_right, .rear_sensors, .cfg_we, .cfg_index, .cfg_data,
		.q_push, .q_data, .q_full
	);

	ltns_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk, .arst_n, .q_push, .q_data, .q_full, .out_valid, .out_ready, .kind,
		.drive_cmd, .drive_speed, .node_tag, .shot_tilt, .shot_pan, .scan_status, .last
	);

endmodule

/* rtl/ltns_front.sv */
module ltns_front import ltns_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] now_ms,
	input  logic        front_left,
	input  logic        front_right,
	input  logic [3:0]  rear_sensors,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        q_push,
	output batch_t      q_data,
	input  logic        q_full
);

	logic [3:0] wp_q;
	logic [7:0] pan_home_q, rounds_q, round_q;
	logic [6:0] tilt_start_q, tilt_step_q, scan_tilt_q, tilt_now_q;
	logic [7:0] pan_now_q;
	logic [1:0] dir_q;
	logic       run_q, latch_q, wact_q;
	logic [3:0] cnt_q;
	logic [2:0] ph_q;
	logic [31:0] wstart_q;
	logic [11:0] wlen_q;

	// Next-state copies worked over by the combinational step.
	logic [7:0] n_rounds, n_round, n_pan_now;
	logic [6:0] n_scan_tilt, n_tilt_now;
	logic [1:0] n_dir;
	logic       n_run, n_latch, n_wact;
	logic [3:0] n_cnt;
	logic [2:0] n_ph;
	logic [31:0] n_wstart;
	logic [11:0] n_wlen;
	batch_t      b;
	logic        fwd, node, sa, sb, expired;
	logic [7:0]  nx;
	logic [4:0]  c5, w5;
	logic [5:0]  code_v;

	assign in_ready = !q_full;
	assign q_push = in_valid && in_ready && (b.cnt != 3'd0);
	assign q_data = b;
	assign expired = wact_q && ((now_ms - wstart_q) >= {20'd0, wlen_q});

	always_comb begin
		n_rounds = rounds_q; n_round = round_q; n_pan_now = pan_now_q;
		n_scan_tilt = scan_tilt_q; n_tilt_now = tilt_now_q; n_dir = dir_q;
		n_run = run_q; n_latch = latch_q; n_wact = wact_q; n_cnt = cnt_q;
		n_ph = ph_q; n_wstart = wstart_q; n_wlen = wlen_q;
		b = '0;
		fwd = (dir_q == DIR_FWD);
		node = 1'b0; sa = 1'b0; sb = 1'b0;
		nx = '0; c5 = '0; w5 = {1'b0, wp_q}; code_v = '0;
		unique case (action)
			ACT_PASS: begin
				if (run_q && (dir_q == DIR_FWD || dir_q == DIR_RET)) begin
					if (ph_q != PH_IDLE) begin
						if (expired) begin
							n_wact = 1'b0;
							if (ph_q == PH_NODE) begin
								c5 = {1'b0, cnt_q};
								code_v = '0;
								// Node handling: report codes, then leave or end the round.
								if (fwd) begin
									if (c5 == 5'd1) code_v = CODE_START;
									else if (c5 >= 5'd2 && c5 <= w5 + 5'd1)
										code_v = CODE_BASE + {2'd0, cnt_q} - 6'd1;
									else if (c5 == w5 + 5'd2) code_v = CODE_BASE;
								end else begin
									if (c5 == 5'd1) code_v = CODE_BASE + {2'd0, wp_q};
									else if (c5 >= 5'd2 && c5 <= w5)
										code_v = CODE_BASE + {2'd0, wp_q} - {2'd0, cnt_q} + 6'd1;
									else if (c5 == w5 + 5'd1) code_v = CODE_START;
								end
								if (code_v != 6'd0) begin
									b.res[0] = mk_node(code_v);
									b.res[1] = mk_shot(scan_tilt_q, pan_home_q);
									b.cnt = 3'd2;
								end
								// The first return node is never the end node, even with no
								// waypoints.
								if ((fwd && c5 == w5 + 5'd2) ||
										(!fwd && c5 == w5 + 5'd1 && c5 != 5'd1)) begin
									if (round_q < rounds_q) begin
										nx = {1'b0, scan_tilt_q} + {1'b0, tilt_step_q};
										if (nx > 8'd90) nx = 8'd85;
										n_scan_tilt = nx[6:0];
										n_tilt_now = nx[6:0];
										n_pan_now = pan_home_q;
										n_wstart = now_ms; n_wlen = NODE_WAIT_MS; n_wact = 1'b1;
										b.res[2] = mk_drive(CMD_STOP, 6'd0);
										b.cnt = 3'd3;
										n_ph = PH_SETTLE;
									end else begin
										n_run = 1'b0; n_cnt = '0; n_latch = 1'b0;
										b.res[2] = mk_status(ST_COMPLETE);
										b.res[3] = mk_drive(CMD_STOP, 6'd0);
										b.cnt = 3'd4;
										n_ph = PH_IDLE;
									end
								end else begin
									n_wstart = now_ms; n_wlen = LEAVE_MS; n_wact = 1'b1;
									b.res[b.cnt[1:0]] = mk_drive(fwd ? CMD_FWD : CMD_BACK, SPEED_TURN);
									b.cnt = b.cnt + 3'd1;
									n_ph = PH_LEAVE;
								end
							end else if (ph_q == PH_LEAVE) begin
								n_ph = PH_IDLE;
							end else if (ph_q == PH_SETTLE) begin
								b.res[0] = mk_shot(tilt_now_q, pan_now_q);
								b.res[1] = mk_drive(CMD_STOP, 6'd0);
								b.cnt = 3'd2;
								n_wstart = now_ms; n_wlen = CAPTURE_MS; n_wact = 1'b1;
								n_ph = PH_CAPTURE;
							end else if (ph_q == PH_CAPTURE) begin
								n_cnt = '0; n_latch = 1'b0; n_ph = PH_IDLE;
								if (round_q >= rounds_q) begin
									b.res[0] = mk_status(ST_COMPLETE);
									b.res[1] = mk_drive(CMD_STOP, 6'd0);
									b.cnt = 3'd2;
									n_run = 1'b0; n_dir = DIR_STOP;
								end else begin
									n_round = round_q + 8'd1;
									// A trace started without a scan enters its first round here.
									if (n_round == 8'd1) begin
										n_scan_tilt = tilt_start_q; n_tilt_now = tilt_start_q;
										n_pan_now = pan_home_q;
									end
									n_dir = n_round[0] ? DIR_FWD : DIR_RET;
									b.res[0] = mk_status(n_round[0] ? ST_GOING : ST_RETURN);
									b.cnt = 3'd1;
								end
							end
						end
					end else begin
						if (fwd) begin
							sa = front_left; sb = front_right; node = sa && sb;
						end else begin
							sa = rear_sensors[0]; sb = rear_sensors[1];
							node = (rear_sensors == 4'hF);
						end
						if (node && !latch_q) begin
							n_latch = 1'b1;
							if (cnt_q < 4'd15) n_cnt = cnt_q + 4'd1;
							if (fwd && round_q > 8'd1 && n_cnt == 4'd1) n_cnt = 4'd2;
							n_wstart = now_ms; n_wlen = NODE_WAIT_MS; n_wact = 1'b1;
							b.res[0] = mk_drive(CMD_STOP, 6'd0);
							b.cnt = 3'd1;
							n_ph = PH_NODE;
						end else begin
							if (!node) n_latch = 1'b0;
							b.cnt = 3'd1;
							if (fwd) begin
								if (!sa && !sb) b.res[0] = mk_drive(CMD_FWD, SPEED_LINE);
								else if (sa && !sb) b.res[0] = mk_drive(CMD_LEFT, SPEED_TURN);
								else if (!sa && sb) b.res[0] = mk_drive(CMD_RIGHT, SPEED_TURN);
								else b.res[0] = mk_drive(CMD_STOP, 6'd0);
							end else begin
								if (sa && sb) b.res[0] = mk_drive(CMD_BACK, SPEED_LINE);
								else if (!sa && sb) b.res[0] = mk_drive(CMD_RIGHT, SPEED_TURN);
								else if (sa && !sb) b.res[0] = mk_drive(CMD_LEFT, SPEED_TURN);
								else b.res[0] = mk_drive(CMD_STOP, 6'd0);
							end
						end
					end
				end
			end
			ACT_SCAN: begin
				if (rounds_q == 8'd0) begin
					n_round = '0;
					b.res[0] = mk_status(ST_COMPLETE);
					b.res[1] = mk_drive(CMD_STOP, 6'd0);
					b.cnt = 3'd2;
					n_run = 1'b0; n_dir = DIR_STOP;
				end else begin
					n_round = 8'd1;
					n_scan_tilt = tilt_start_q; n_tilt_now = tilt_start_q;
					n_pan_now = pan_home_q;
					n_dir = DIR_FWD;
					b.res[0] = mk_status(ST_GOING);
					b.cnt = 3'd1;
					n_run = 1'b1; n_cnt = '0; n_latch = 1'b0; n_ph = PH_IDLE;
				end
			end
			ACT_TRACE: begin
				if (!run_q) begin
					n_dir = DIR_FWD; n_run = 1'b1; n_cnt = '0; n_latch = 1'b0;
					n_ph = PH_IDLE;
				end
			end
			ACT_STOP: begin
				n_run = 1'b0; n_dir = DIR_STOP; n_round = '0; n_rounds = '0;
				n_cnt = '0; n_latch = 1'b0; n_ph = PH_IDLE; n_wact = 1'b0;
				b.res[0] = mk_drive(CMD_STOP, 6'd0);
				b.res[1] = mk_status(ST_STOPPED);
				b.cnt = 3'd2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; pan_home_q <= 8'd90; tilt_start_q <= '0; tilt_step_q <= 7'd10;
			rounds_q <= '0; round_q <= '0; scan_tilt_q <= '0; tilt_now_q <= 7'd90;
			pan_now_q <= 8'd90; dir_q <= DIR_STOP; run_q <= 1'b0; latch_q <= 1'b0;
			wact_q <= 1'b0; cnt_q <= '0; ph_q <= PH_IDLE; wstart_q <= '0; wlen_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				rounds_q <= n_rounds; round_q <= n_round; pan_now_q <= n_pan_now;
				scan_tilt_q <= n_scan_tilt; tilt_now_q <= n_tilt_now; dir_q <= n_dir;
				run_q <= n_run; latch_q <= n_latch; wact_q <= n_wact; cnt_q <= n_cnt;
				ph_q <= n_ph; wstart_q <= n_wstart; wlen_q <= n_wlen;
			end else if (cfg_we) begin
				unique case (cfg_index)
					REG_WAYPOINTS: wp_q <= (cfg_data[3:0] > 4'd9) ? 4'd1 : cfg_data[3:0];
					REG_PAN: pan_home_q <= (cfg_data > 8'd180) ? 8'd180 : cfg_data;
					REG_TILT: tilt_start_q <= (cfg_data[6:0] > 7'd90) ? 7'd90 : cfg_data[6:0];
					REG_STEP: tilt_step_q <= (cfg_data[6:0] == 7'd0) ? 7'd1 :
						((cfg_data[6:0] > 7'd90) ? 7'd90 : cfg_data[6:0]);
					REG_ROUNDS: rounds_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

/* rtl/ltns_back.sv */
module ltns_back import ltns_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_push,
	input  batch_t     q_data,
	output logic       q_full,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [2:0] drive_cmd,
	output logic [5:0] drive_speed,
	output logic [5:0] node_tag,
	output logic [6:0] shot_tilt,
	output logic [7:0] shot_pan,
	output logic [1:0] scan_status,
	output logic       last
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	batch_t mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   fill_q;
	logic [2:0]    idx_q;
	logic          pop, load;
	res_t          r;
	batch_t        head;

	assign head = mem_q[rd_q];
	assign q_full = (fill_q == (AW+1)'(QUEUE_DEPTH));
	assign load = out_valid && out_ready;
	// A batch leaves the queue when its final word is taken.
	assign pop = load && ((idx_q + 3'd1) == head.cnt);
	assign out_valid = (fill_q != '0);
	assign r = head.res[idx_q];
	assign kind = r.kind;
	assign drive_cmd = r.drive_cmd;
	assign drive_speed = r.drive_speed;
	assign node_tag = r.node_tag;
	assign shot_tilt = r.shot_tilt;
	assign shot_pan = r.shot_pan;
	assign scan_status = r.scan_status;
	assign last = ((idx_q + 3'd1) == head.cnt);

	always_ff @(posedge clk) begin
		if (q_push) mem_q[wr_q] <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; fill_q <= '0; idx_q <= '0;
		end else begin
			if (q_push) wr_q <= (wr_q == AW'(QUEUE_DEPTH-1)) ? '0 : wr_q + AW'(1);
			if (pop) rd_q <= (rd_q == AW'(QUEUE_DEPTH-1)) ? '0 : rd_q + AW'(1);
			if (load) idx_q <= pop ? 3'd0 : idx_q + 3'd1;
			fill_q <= fill_q + (AW+1)'(q_push) - (AW+1)'(pop);
		end
	end

endmodule

/* dv/line_track_node_scan_controller_tb.sv */
`timescale 1ns / 100ps

module line_track_node_scan_controller_tb;
	import ltns_pkg::*;

	typedef struct {
		logic [1:0]  action;
		logic [31:0] now_ms;
		logic        fl;
		logic        fr;
		logic [3:0]  rear;
	} word_t;

	typedef struct {
		res_t r;
		logic last;
	} result_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  action = ACT_PASS;
	logic [31:0] now_ms = '0;
	logic        front_left = 0;
	logic        front_right = 0;
	logic [3:0]  rear_sensors = '0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = REG_WAYPOINTS;
	logic [7:0]  cfg_data = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  kind;
	logic [2:0]  drive_cmd;
	logic [5:0]  drive_speed;
	logic [5:0]  node_tag;
	logic [6:0]  shot_tilt;
	logic [7:0]  shot_pan;
	logic [1:0]  scan_status;
	logic        last;

	line_track_node_scan_controller uut (.*);

	word_t   pending_words[$];
	result_t expected_results[$];
	word_t   cur_word;
	int      idle_in = 0;
	int      stall_out = 0;
	int      quiet_cycles = 0;
	bit      failed = 0;
	logic [31:0] clock_ms = '0;

	// Shadow of the block's registers and scan state.
	logic [3:0]  m_waypoints;
	logic [7:0]  m_pan_home, m_rounds, m_round;
	logic [6:0]  m_tilt_start, m_tilt_step, m_scan_tilt, m_tilt_now;
	logic [7:0]  m_pan_now;
	logic [1:0]  m_dir;
	logic        m_running, m_latch, m_wait_on;
	logic [3:0]  m_nodes;
	logic [2:0]  m_phase;
	logic [31:0] m_wait_start, m_now;
	logic [11:0] m_wait_len;
	int          n_out;

	function automatic void add_result(logic [1:0] k, logic [2:0] c, logic [5:0] s,
			logic [5:0] code, logic [6:0] t, logic [7:0] p, logic [1:0] st);
		result_t e;
		if (n_out >= MAX_RES)
			return;
		e.r = '0;
		e.r.kind = k;
		e.r.drive_cmd = c;
		e.r.drive_speed = s;
		e.r.node_tag = code;
		e.r.shot_tilt = t;
		e.r.shot_pan = p;
		e.r.scan_status = st;
		e.last = 0;
		expected_results.push_back(e);
		n_out++;
	endfunction

	function automatic void motor(logic [2:0] c, logic [5:0] s, logic [11:0] ms);
		if (ms != 0) begin
			m_wait_start = m_now;
			m_wait_len = ms;
			m_wait_on = 1;
		end
		add_result(KIND_DRIVE, c, s, 0, 0, 0, 0);
	endfunction

	function automatic void node_report(logic [5:0] code);
		add_result(KIND_NODE, 0, 0, code, 0, 0, 0);
		add_result(KIND_SHOT, 0, 0, 0, m_scan_tilt, m_pan_home, 0);
	endfunction

	function automatic void begin_round();
		if (m_round >= m_rounds) begin
			add_result(KIND_STATUS, 0, 0, 0, 0, 0, ST_COMPLETE);
			m_running = 0;
			m_dir = DIR_STOP;
			motor(CMD_STOP, 0, 0);
			return;
		end
		m_round = m_round + 1;
		if (m_round == 1) begin
			m_scan_tilt = m_tilt_start;
			m_pan_now = m_pan_home;
			m_tilt_now = m_tilt_start;
		end
		if (m_round[0]) begin
			m_dir = DIR_FWD;
			add_result(KIND_STATUS, 0, 0, 0, 0, 0, ST_GOING);
		end else begin
			m_dir = DIR_RET;
			add_result(KIND_STATUS, 0, 0, 0, 0, 0, ST_RETURN);
		end
		m_running = 1;
		m_nodes = 0;
		m_latch = 0;
		m_phase = PH_IDLE;
	endfunction

	function automatic void last_node();
		int nx;
		if (m_round < m_rounds) begin
			nx = m_scan_tilt + m_tilt_step;
			if (nx > 90)
				nx = 85;
			m_scan_tilt = 7'(nx);
			m_pan_now = m_pan_home;
			m_tilt_now = 7'(nx);
			motor(CMD_STOP, 0, NODE_WAIT_MS);
			m_phase = PH_SETTLE;
		end else begin
			m_running = 0;
			m_nodes = 0;
			m_latch = 0;
			add_result(KIND_STATUS, 0, 0, 0, 0, 0, ST_COMPLETE);
			motor(CMD_STOP, 0, 0);
			m_phase = PH_IDLE;
		end
	endfunction

	function automatic void at_node(bit fwd);
		int c, w;
		c = m_nodes;
		w = m_waypoints;
		if (fwd) begin
			if (c == 1)
				node_report(CODE_START);
			else if (c >= 2 && c <= w + 1)
				node_report(6'(CODE_BASE + c - 1));
			else if (c == w + 2) begin
				node_report(CODE_BASE);
				last_node();
				return;
			end
			motor(CMD_FWD, SPEED_TURN, LEAVE_MS);
		end else begin
			if (c == 1)
				node_report(6'(CODE_BASE + w));
			else if (c >= 2 && c <= w)
				node_report(6'(CODE_BASE + w - (c - 1)));
			else if (c == w + 1) begin
				node_report(CODE_START);
				last_node();
				return;
			end
			motor(CMD_BACK, SPEED_TURN, LEAVE_MS);
		end
		m_phase = PH_LEAVE;
	endfunction

	function automatic void follow_line(word_t w);
		bit fwd, is_node, a, b;
		fwd = (m_dir == DIR_FWD);
		if (m_phase != PH_IDLE) begin
			if (m_wait_on && (m_now - m_wait_start) >= {20'd0, m_wait_len}) begin
				m_wait_on = 0;
				if (m_phase == PH_NODE) begin
					m_phase = PH_REPORT;
					at_node(fwd);
				end else if (m_phase == PH_LEAVE) begin
					m_phase = PH_IDLE;
				end else if (m_phase == PH_SETTLE) begin
					add_result(KIND_SHOT, 0, 0, 0, m_tilt_now, m_pan_now, 0);
					motor(CMD_STOP, 0, CAPTURE_MS);
					m_phase = PH_CAPTURE;
				end else if (m_phase == PH_CAPTURE) begin
					m_nodes = 0;
					m_latch = 0;
					begin_round();
					m_phase = PH_IDLE;
				end
			end
			return;
		end
		if (fwd) begin
			a = w.fl;
			b = w.fr;
			is_node = a && b;
		end else begin
			a = w.rear[0];
			b = w.rear[1];
			is_node = (w.rear == 4'hf);
		end
		if (is_node && !m_latch && m_running) begin
			m_latch = 1;
			if (m_nodes < 15)
				m_nodes++;
			if (fwd && m_round > 1 && m_nodes == 1)
				m_nodes = 2;
			motor(CMD_STOP, 0, NODE_WAIT_MS);
			m_phase = PH_NODE;
		end else if (!is_node) begin
			m_latch = 0;
		end
		if (m_running && m_phase == PH_IDLE) begin
			if (fwd) begin
				if (!a && !b)     motor(CMD_FWD, SPEED_LINE, 0);
				else if (a && !b) motor(CMD_LEFT, SPEED_TURN, 0);
				else if (!a && b) motor(CMD_RIGHT, SPEED_TURN, 0);
				else              motor(CMD_STOP, 0, 0);
			end else begin
				if (a && b)       motor(CMD_BACK, SPEED_LINE, 0);
				else if (!a && b) motor(CMD_RIGHT, SPEED_TURN, 0);
				else if (a && !b) motor(CMD_LEFT, SPEED_TURN, 0);
				else              motor(CMD_STOP, 0, 0);
			end
		end
	endfunction

	function automatic void predict_word(word_t w);
		n_out = 0;
		m_now = w.now_ms;
		case (w.action)
			ACT_PASS: begin
				if (m_running && (m_dir == DIR_FWD || m_dir == DIR_RET))
					follow_line(w);
			end
			ACT_SCAN: begin
				m_round = 0;
				begin_round();
			end
			ACT_TRACE: begin
				if (!m_running) begin
					m_dir = DIR_FWD;
					m_running = 1;
					m_nodes = 0;
					m_latch = 0;
					m_phase = PH_IDLE;
				end
			end
			default: begin
				m_running = 0;
				m_dir = DIR_STOP;
				m_round = 0;
				m_rounds = 0;
				m_nodes = 0;
				m_latch = 0;
				m_phase = PH_IDLE;
				m_wait_on = 0;
				motor(CMD_STOP, 0, 0);
				add_result(KIND_STATUS, 0, 0, 0, 0, 0, ST_STOPPED);
			end
		endcase
		if (n_out > 0)
			expected_results[$].last = 1;
	endfunction

	function automatic void shadow_reset();
		m_waypoints = 0; m_pan_home = 90; m_tilt_start = 0; m_tilt_step = 10;
		m_rounds = 0; m_dir = DIR_STOP; m_running = 0; m_nodes = 0; m_latch = 0;
		m_phase = PH_IDLE; m_wait_on = 0; m_wait_start = 0; m_wait_len = 0;
		m_round = 0; m_scan_tilt = 0; m_tilt_now = 90; m_pan_now = 90;
	endfunction

	function automatic void shadow_write(logic [2:0] idx, logic [7:0] v);
		case (idx)
			REG_WAYPOINTS: m_waypoints = (v[3:0] > 9) ? 4'd1 : v[3:0];
			REG_PAN:       m_pan_home = (v > 180) ? 8'd180 : v;
			REG_TILT:      m_tilt_start = (v[6:0] > 90) ? 7'd90 : v[6:0];
			REG_STEP:      m_tilt_step = (v[6:0] < 1) ? 7'd1 :
					((v[6:0] > 90) ? 7'd90 : v[6:0]);
			REG_ROUNDS:    m_rounds = v;
			default: ;
		endcase
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			predict_word(cur_word);
		if (!in_valid || in_ready) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= idle_in) begin
				cur_word = pending_words.pop_front();
				in_valid <= 1;
				action <= cur_word.action;
				now_ms <= cur_word.now_ms;
				front_left <= cur_word.fl;
				front_right <= cur_word.fr;
				rear_sensors <= cur_word.rear;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n)
			out_ready <= ($urandom_range(99) >= stall_out);
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: kind %0d", kind);
				failed = 1;
			end else begin
				e = expected_results.pop_front();
				if (kind !== e.r.kind) begin
					$error("kind: expected %0d, got %0d", e.r.kind, kind); failed = 1;
				end
				if (drive_cmd !== e.r.drive_cmd) begin
					$error("drive_cmd: expected %0d, got %0d", e.r.drive_cmd, drive_cmd);
					failed = 1;
				end
				if (drive_speed !== e.r.drive_speed) begin
					$error("drive_speed: expected %0d, got %0d", e.r.drive_speed,
						drive_speed);
					failed = 1;
				end
				if (node_tag !== e.r.node_tag) begin
					$error("node_tag: expected %0d, got %0d", e.r.node_tag, node_tag);
					failed = 1;
				end
				if (shot_tilt !== e.r.shot_tilt) begin
					$error("shot_tilt: expected %0d, got %0d", e.r.shot_tilt, shot_tilt);
					failed = 1;
				end
				if (shot_pan !== e.r.shot_pan) begin
					$error("shot_pan: expected %0d, got %0d", e.r.shot_pan, shot_pan);
					failed = 1;
				end
				if (scan_status !== e.r.scan_status) begin
					$error("scan_status: expected %0d, got %0d", e.r.scan_status,
						scan_status);
					failed = 1;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last); failed = 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		shadow_write(idx, v);
	endtask

	task automatic configure(logic [7:0] wp, logic [7:0] pan, logic [7:0] tilt,
			logic [7:0] step, logic [7:0] rounds);
		cfg_write(REG_WAYPOINTS, wp);
		cfg_write(REG_PAN, pan);
		cfg_write(REG_TILT, tilt);
		cfg_write(REG_STEP, step);
		cfg_write(REG_ROUNDS, rounds);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic push_word(logic [1:0] act, logic [31:0] step_ms, logic fl, logic fr,
			logic [3:0] rear);
		word_t w;
		clock_ms = clock_ms + step_ms;
		w.action = act;
		w.now_ms = clock_ms;
		w.fl = fl;
		w.fr = fr;
		w.rear = rear;
		pending_words.push_back(w);
	endtask

	// Mostly line-following passes, with node patterns often enough that the
	// timed phases and round changes are reached; a few commands as noise.
	task automatic random_words(int n);
		int r;
		bit on_node;
		push_word(ACT_SCAN, $urandom_range(0, 50), 0, 0, 0);
		repeat (n) begin
			r = $urandom_range(99);
			on_node = ($urandom_range(99) < 35);
			if (r < 3)
				push_word(ACT_STOP, $urandom_range(0, 100), 1'($urandom), 1'($urandom),
					4'($urandom));
			else if (r < 7)
				push_word(ACT_SCAN, $urandom_range(0, 100), 1'($urandom), 1'($urandom),
					4'($urandom));
			else if (r < 10)
				push_word(ACT_TRACE, $urandom_range(0, 100), 1'($urandom), 1'($urandom),
					4'($urandom));
			else if (on_node)
				push_word(ACT_PASS, $urandom_range(0, 1600), 1, 1, 4'hf);
			else
				push_word(ACT_PASS, $urandom_range(0, 1600), 1'($urandom), 1'($urandom),
					4'($urandom));
		end
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		shadow_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: idle passes, trace on every front pattern, repeated trace, stop,
		// zero-round scan, then a two-round scan through its forward nodes into the return round.
		push_word(ACT_PASS, 0, 1, 1, 4'hf);
		push_word(ACT_TRACE, 1, 0, 0, 0);
		push_word(ACT_TRACE, 1, 0, 0, 0);
		push_word(ACT_PASS, 1, 0, 0, 0);
		push_word(ACT_PASS, 1, 1, 0, 0);
		push_word(ACT_PASS, 1, 0, 1, 0);
		push_word(ACT_PASS, 1, 1, 1, 4'hf);
		push_word(ACT_PASS, 3000, 0, 0, 0);
		push_word(ACT_PASS, 250, 0, 0, 0);
		push_word(ACT_STOP, 1, 0, 0, 0);
		push_word(ACT_SCAN, 1, 0, 0, 0);
		drain();
		configure(8'd12, 8'd255, 8'd127, 8'd0, 8'd2);
		clock_ms = 32'hffff_f000;
		push_word(ACT_SCAN, 0, 0, 0, 0);
		for (int i = 0; i < 4; i++) begin
			push_word(ACT_PASS, 5, 1, 1, 4'hf);
			push_word(ACT_PASS, 3000, 0, 0, 0);
			push_word(ACT_PASS, 250, 0, 0, 0);
			push_word(ACT_PASS, 3000, 0, 0, 0);
		end
		push_word(ACT_PASS, 500, 0, 0, 4'h1);
		push_word(ACT_PASS, 1, 0, 0, 4'h2);
		push_word(ACT_PASS, 1, 0, 0, 4'h3);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin idle_in = 0;  stall_out = 0;  end
				1: begin idle_in = 55; stall_out = 0;  end
				2: begin idle_in = 0;  stall_out = 55; end
				default: begin idle_in = 18; stall_out = 18; end
			endcase
			case (p)
				0: configure(8'd0, 8'd0, 8'd0, 8'd1, 8'd0);
				1: configure(8'd9, 8'd180, 8'd90, 8'd90, 8'd255);
				2: configure(8'd1, 8'd200, 8'd85, 8'd5, 8'd3);
				3: configure(8'd15, 8'd45, 8'd100, 8'd127, 8'd4);
				default: configure(8'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom_range(1, 5)));
			endcase
			if ($urandom_range(1))
				clock_ms = $urandom;
			random_words(34);
			drain();
		end

		if (!failed)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
